[hdl/bshd_pkg.sv]
// Shared types and constants for the brake sensor hysteresis detector.
`timescale 1ns / 1ps
`default_nettype none

package bshd_pkg;

  localparam int CAL_SAMPLES = 50;
  localparam int SAMPLE_BITS = 12;
  localparam int CNT_BITS    = 6;
  localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS;
  localparam int TIME_BITS   = 32;
  localparam int THR_BITS    = 12;
  localparam int TMO_BITS    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Divide by CAL_SAMPLES as multiply by a rounded-up reciprocal. The rounding
  // error is below CAL_SAMPLES, so x * err < 2^DIV_SHIFT for any x < 2^SUM_BITS.
  localparam int DIV_SHIFT  = SUM_BITS + CNT_BITS;
  localparam int DIV_W      = DIV_SHIFT + 1;
  localparam logic [DIV_W-1:0] DIV_MULT =
      DIV_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam int PROD_W     = SUM_BITS + DIV_W;

  localparam logic [THR_BITS-1:0] PRESS_THR_RST   = THR_BITS'(300);
  localparam logic [THR_BITS-1:0] RELEASE_THR_RST = THR_BITS'(150);
  localparam logic [TMO_BITS-1:0] TIMEOUT_RST     = TMO_BITS'(100);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PRESS_THR   = 2'd0,
    CFG_RELEASE_THR = 2'd1,
    CFG_TIMEOUT     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                   func;
    logic [TIME_BITS-1:0]   now_ms;
    logic [SAMPLE_BITS-1:0] brake_sample;
    logic                   recalibrate;
  } in_item_t;

  typedef struct packed {
    logic                   pressed;
    logic                   calibrated;
    logic [SAMPLE_BITS-1:0] baseline;
    logic [SAMPLE_BITS-1:0] last_delta;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/bshd_in_if.sv]
// Input item channel: valid/ready handshake with the sample payload.
`timescale 1ns / 1ps
`default_nettype none

interface bshd_in_if;
  import bshd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/bshd_out_if.sv]
// Result item channel: valid/ready handshake with the detector status.
`timescale 1ns / 1ps
`default_nettype none

interface bshd_out_if;
  import bshd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/bshd_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface bshd_cfg_if;
  import bshd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  idx;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

[hdl/brake_sensor_hysteresis_detector_unit.sv]
// Brake sensor detector: baseline calibration, timeout and hysteresis compare.
//
//   channel | dir | payload                                      | transaction
//   --------+-----+----------------------------------------------+-------------------
//   cfg_i   | in  | idx, wdata (0 press, 1 release, 2 timeout)   | valid & ready
//   in_i    | in  | func, now_ms, brake_sample, recalibrate      | valid & ready
//   out_o   | out | pressed, calibrated, baseline, last_delta    | valid & ready
//
// One transaction per cycle sustained while out_o is ready. A result goes through the input
// register, then is computed into the result register, where it becomes valid. Each item
// sees the state left by the one before it; the baseline divide is one multiply by a
// constant reciprocal. Reset clears the valid flags and the detector state and loads the
// register defaults. A stalled output holds the input register and drops in_i.ready once
// both registers are full; cfg_i is always ready.
`timescale 1ns / 1ps
`default_nettype none

module brake_sensor_hysteresis_detector_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  bshd_cfg_if.sink     cfg_i,
  bshd_in_if.sink      in_i,
  bshd_out_if.source   out_o
);
  import bshd_pkg::*;

  // configuration registers
  logic [THR_BITS-1:0] press_thr_q;
  logic [THR_BITS-1:0] release_thr_q;
  logic [TMO_BITS-1:0] timeout_q;

  // input register
  logic     s1_valid_q;
  in_item_t s1_q;

  // detector state
  logic [TIME_BITS-1:0]   last_time_q, last_time_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] base_q, base_d;
  logic                   cal_q, cal_d;
  logic                   pressed_q, pressed_d;
  logic [SAMPLE_BITS-1:0] delta_q, delta_d;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  logic                   s1_adv;
  logic [TIME_BITS-1:0]   elapsed;
  logic [SUM_BITS-1:0]    sum_add;
  logic [CNT_BITS-1:0]    cnt_add;
  logic [PROD_W-1:0]      quot_prod;
  logic [SAMPLE_BITS-1:0] abs_diff;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q   <= PRESS_THR_RST;
      release_thr_q <= RELEASE_THR_RST;
      timeout_q     <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_PRESS_THR:   press_thr_q   <= cfg_i.wdata[THR_BITS-1:0];
        CFG_RELEASE_THR: release_thr_q <= cfg_i.wdata[THR_BITS-1:0];
        CFG_TIMEOUT:     timeout_q     <= cfg_i.wdata[TMO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Compute stage. Recalibrate first clears the detector state except the last timestamp, then the item runs as usual.
  always_comb begin
    last_time_d = last_time_q;
    cnt_d       = s1_q.recalibrate ? '0 : cnt_q;
    sum_d       = s1_q.recalibrate ? '0 : sum_q;
    base_d      = s1_q.recalibrate ? '0 : base_q;
    cal_d       = s1_q.recalibrate ? 1'b0 : cal_q;
    pressed_d   = s1_q.recalibrate ? 1'b0 : pressed_q;
    delta_d     = s1_q.recalibrate ? '0 : delta_q;

    elapsed   = s1_q.now_ms - last_time_q;
    sum_add   = sum_d + SUM_BITS'(s1_q.brake_sample);
    cnt_add   = cnt_d + CNT_BITS'(1);
    quot_prod = PROD_W'(sum_add) * PROD_W'(DIV_MULT);
    abs_diff  = (s1_q.brake_sample >= base_d) ? (s1_q.brake_sample - base_d)
                                              : (base_d - s1_q.brake_sample);

    if (!s1_q.func) begin
      if (elapsed > TIME_BITS'(timeout_q)) begin
        pressed_d = 1'b0;
      end
    end else begin
      last_time_d = s1_q.now_ms;
      if (!cal_d) begin
        sum_d = sum_add;
        cnt_d = cnt_add;
        if (cnt_add >= CNT_BITS'(CAL_SAMPLES)) begin
          base_d = quot_prod[DIV_SHIFT +: SAMPLE_BITS];
          cal_d  = 1'b1;
        end
      end else begin
        delta_d = abs_diff;
        if (!pressed_d) begin
          if (abs_diff >= press_thr_q) begin
            pressed_d = 1'b1;
          end
        end else if (abs_diff <= release_thr_q) begin
          pressed_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_time_q <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      base_q      <= '0;
      cal_q       <= 1'b0;
      pressed_q   <= 1'b0;
      delta_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        last_time_q <= last_time_d;
        cnt_q       <= cnt_d;
        sum_q       <= sum_d;
        base_q      <= base_d;
        cal_q       <= cal_d;
        pressed_q   <= pressed_d;
        delta_q     <= delta_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (s1_adv) begin
      out_q.pressed    <= pressed_d;
      out_q.calibrated <= cal_d;
      out_q.baseline   <= base_d;
      out_q.last_delta <= delta_d;
    end
  end

`ifndef SYNTHESIS
  a_cal_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |-> cnt_q == CNT_BITS'(CAL_SAMPLES))
    else $error("calibrated without a full sample count");

  a_uncal_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |-> cnt_q < CNT_BITS'(CAL_SAMPLES))
    else $error("sample count reached limit while uncalibrated");

  a_uncal_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |-> !pressed_q && base_q == '0 && delta_q == '0)
    else $error("pressed, baseline or delta set before calibration");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result raised without an item in the input register");
`endif

endmodule

`default_nettype wire
